>>> src/dnps_pkg.sv
// Shared constants, types and table builder for the day/night pixel shader.
// Depends on nothing; every other file imports it.
package dnps_pkg;

    // Map and angle geometry
    localparam int MAX_WIDTH          = 256;
    localparam int TRIG_FRACTION_BITS = 16;
    localparam int ANG_W              = 16;
    localparam int X_W                = 8;
    localparam int Y_W                = 7;
    localparam int H_W                = 8;
    localparam int W_W                = 9;
    localparam int PIX_W              = 8;
    localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;

    // Quarter-wave sine table
    localparam int TAB_TOP  = 1024;
    localparam int TAB_SIZE = TAB_TOP + 1;
    localparam int TAB_AW   = $clog2(TAB_SIZE);
    localparam int TAB_DW   = TRIG_FRACTION_BITS + 1;
    localparam int SV_W     = TAB_DW + 1;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int SERIES_TERMS = 6;
    localparam longint unsigned TERM_DIV [SERIES_TERMS] = '{6, 20, 42, 72, 110, 156};

    // Pipelined long division
    localparam int DEN_W      = ($clog2(MAX_WIDTH) + 1 > H_W + 1) ?
                                ($clog2(MAX_WIDTH) + 1) : (H_W + 1);
    localparam int NUM_W      = X_W + ANG_W;
    localparam int QUO_W      = ANG_W;
    localparam int DIV_STEP   = 4;
    localparam int DIV_STAGES = (NUM_W + DIV_STEP - 1) / DIV_STEP;

    // Register map
    localparam int ADDR_W = 5;
    localparam logic [2:0] REG_SUN_LON = 3'd0;
    localparam logic [2:0] REG_SUN_DEC = 3'd1;
    localparam logic [2:0] REG_WIDTH   = 3'd2;
    localparam logic [2:0] REG_HEIGHT  = 3'd3;
    localparam logic [2:0] REG_MONO    = 3'd4;

    typedef logic [TAB_DW-1:0] sin_tab_t [TAB_SIZE];

    // Table read request: quarter-wave address and sign of the result
    typedef struct packed {
        logic [TAB_AW-1:0] addr;
        logic              neg;
    } sin_req_t;

    // One table entry, round(sin(i*pi/2048) * 2^F) by a truncated series
    function automatic logic [TAB_DW-1:0] quarter_entry(int unsigned i);
        longint unsigned t;
        longint unsigned term;
        longint          sum;
        t    = (longint'(i) * PI_Q30) >> 11;
        term = t;
        sum  = longint'(t);
        for (int k = 1; k <= SERIES_TERMS; k++)
        begin
            term = (((term * t) >> 30) * t) >> 30;
            term = term / TERM_DIV[k-1];
            if (k % 2 == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        sum = (sum + (longint'(1) << (30 - TRIG_FRACTION_BITS - 1)))
              >>> (30 - TRIG_FRACTION_BITS);
        return TAB_DW'(sum);
    endfunction

    function automatic sin_tab_t build_sin_tab();
        sin_tab_t tab;
        for (int i = 0; i < TAB_SIZE; i++)
            tab[i] = quarter_entry(i);
        return tab;
    endfunction

    // Fold a full-turn angle onto the quarter-wave table
    function automatic sin_req_t sin_req(logic [ANG_W-1:0] a);
        sin_req_t r;
        logic [TAB_AW-1:0] j;
        j = TAB_AW'(a[ANG_W-3:4]);
        r.addr = a[ANG_W-2] ? (TAB_AW'(TAB_TOP) - j) : j;
        r.neg  = a[ANG_W-1];
        return r;
    endfunction

endpackage

>>> src/dnps_sin_rom.sv
// Quarter-wave sine ROM with one registered read port.
// Depends on dnps_pkg for the table contents and widths.
module dnps_sin_rom import dnps_pkg::*;
(
    input  logic              clk,
    input  logic [TAB_AW-1:0] addr,
    output logic [TAB_DW-1:0] data
);

    localparam sin_tab_t TAB = build_sin_tab();

    logic [TAB_DW-1:0] data_reg;

    // Register the table read
    always_ff @(posedge clk)
    begin
        data_reg <= TAB[addr];
    end

    assign data = data_reg;

endmodule

>>> src/dnps_div.sv
// Pipelined restoring divider, DIV_STEP quotient bits per stage.
// Depends on dnps_pkg; keeps the low QUO_W bits of the quotient.
module dnps_div import dnps_pkg::*;
(
    input  logic             clk,
    input  logic [NUM_W-1:0] num_in,
    input  logic [DEN_W-1:0] den_in,
    output logic [QUO_W-1:0] quo_out
);

    logic [NUM_W-1:0] num_reg [DIV_STAGES];
    logic [DEN_W-1:0] rem_reg [DIV_STAGES];
    logic [QUO_W-1:0] quo_reg [DIV_STAGES];
    logic [DEN_W-1:0] den_reg [DIV_STAGES];

    for (genvar s = 0; s < DIV_STAGES; s++)
    begin : g_stage
        logic [NUM_W-1:0] n_in;
        logic [DEN_W-1:0] r_in;
        logic [QUO_W-1:0] q_in;
        logic [DEN_W-1:0] d_in;
        logic [NUM_W-1:0] num_next;
        logic [DEN_W-1:0] rem_next;
        logic [QUO_W-1:0] quo_next;

        if (s == 0)
        begin : g_first
            assign n_in = num_in;
            assign r_in = '0;
            assign q_in = '0;
            assign d_in = den_in;
        end
        else
        begin : g_rest
            assign n_in = num_reg[s-1];
            assign r_in = rem_reg[s-1];
            assign q_in = quo_reg[s-1];
            assign d_in = den_reg[s-1];
        end

        // Shift in numerator bits, subtract where the divisor fits
        always_comb
        begin
            logic [DEN_W:0] sh;
            num_next = n_in;
            rem_next = r_in;
            quo_next = q_in;
            for (int k = 0; k < DIV_STEP; k++)
            begin
                sh       = {rem_next, num_next[NUM_W-1]};
                num_next = {num_next[NUM_W-2:0], 1'b0};
                if (sh >= {1'b0, d_in})
                begin
                    rem_next = DEN_W'(sh - {1'b0, d_in});
                    quo_next = {quo_next[QUO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = sh[DEN_W-1:0];
                    quo_next = {quo_next[QUO_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            num_reg[s] <= num_next;
            rem_reg[s] <= rem_next;
            quo_reg[s] <= quo_next;
            den_reg[s] <= d_in;
        end
    end

    assign quo_out = quo_reg[DIV_STAGES-1];

endmodule

>>> src/day_night_pixel_shader_top.sv
// Day/night pixel shader: config registers, shading pipeline, output stage.
// Depends on dnps_pkg, dnps_div and dnps_sin_rom.
//
// Usage
//   Input items: pixel_x, pixel_y, day_pixel, night_pixel, taken at a
//   rising edge with start high and busy low. busy is always low, so one
//   item may be issued in every cycle.
//   Results: pixel_out and is_dark, shown for exactly one cycle with done
//   high, in issue order. Throughput is one item per cycle. Each item
//   passes through eleven register stages: six divider stages
//   (longitude and latitude), a registered sine ROM read, sign apply, two
//   multiply stages and the sum/select output register.
//   Configuration: APB registers sun_longitude (0x00), sun_declination
//   (0x04), image_width (0x08), image_height (0x0C), mono_mode (0x10);
//   pready is always high. Write them only while no item is in flight.
//   Reset clears the pipeline valid bits and loads the register defaults;
//   the receiver cannot stall, so no result is ever held back.
module day_night_pixel_shader_top import dnps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [X_W-1:0]    pixel_x,
    input  logic [Y_W-1:0]    pixel_y,
    input  logic [PIX_W-1:0]  day_pixel,
    input  logic [PIX_W-1:0]  night_pixel,
    output logic              done,
    output logic [PIX_W-1:0]  pixel_out,
    output logic              is_dark,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int PIPE_LAT = DIV_STAGES + 4;
    localparam int ST_R  = DIV_STAGES;
    localparam int ST_T  = DIV_STAGES + 1;
    localparam int ST_M1 = DIV_STAGES + 2;
    localparam int ST_M2 = DIV_STAGES + 3;
    localparam int P1_W  = 2 * SV_W;
    localparam int P3_W  = 3 * SV_W;
    localparam int SUM_W = 3 * SV_W + 1;

    logic [ANG_W-1:0] sun_lon_reg;
    logic [13:0]      sun_dec_reg;
    logic [W_W-1:0]   width_reg;
    logic [H_W-1:0]   height_reg;
    logic             mono_reg;

    logic [2:0] reg_idx;
    logic       wr_en;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite & pready;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sun_lon_reg <= '0;
            sun_dec_reg <= '0;
            width_reg   <= W_W'(MAX_WIDTH);
            height_reg  <= H_W'(128);
            mono_reg    <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_SUN_LON: sun_lon_reg <= pwdata[ANG_W-1:0];
                REG_SUN_DEC: sun_dec_reg <= pwdata[13:0];
                REG_WIDTH:   width_reg   <= pwdata[W_W-1:0];
                REG_HEIGHT:  height_reg  <= pwdata[H_W-1:0];
                REG_MONO:    mono_reg    <= pwdata[0];
                default:     ;
            endcase
        end
    end

    // Return register contents on read
    always_comb
    begin
        unique case (reg_idx)
            REG_SUN_LON: prdata = 32'(sun_lon_reg);
            REG_SUN_DEC: prdata = 32'(sun_dec_reg);
            REG_WIDTH:   prdata = 32'(width_reg);
            REG_HEIGHT:  prdata = 32'(height_reg);
            REG_MONO:    prdata = 32'(mono_reg);
            default:     prdata = '0;
        endcase
    end

    // Clamp the divisors
    logic [DEN_W-1:0] width_eff;
    logic [H_W-1:0]   height_eff;
    logic [DEN_W-1:0] lat_den;

    always_comb
    begin
        if (width_reg == '0)
            width_eff = DEN_W'(1);
        else if (32'(width_reg) > MAX_WIDTH)
            width_eff = DEN_W'(MAX_WIDTH);
        else
            width_eff = DEN_W'(width_reg);
        height_eff = (height_reg == '0) ? H_W'(1) : height_reg;
        lat_den    = DEN_W'({height_eff, 1'b0});
    end

    // Valid bits and pixel payload travel alongside the data
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIX_W-1:0]    day_reg   [PIPE_LAT];
    logic [PIX_W-1:0]    night_reg [PIPE_LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[PIPE_LAT-2:0], start & ~busy};
    end

    always_ff @(posedge clk)
    begin
        day_reg[0]   <= day_pixel;
        night_reg[0] <= night_pixel;
        for (int i = 1; i < PIPE_LAT; i++)
        begin
            day_reg[i]   <= day_reg[i-1];
            night_reg[i] <= night_reg[i-1];
        end
    end

    // Longitude and latitude angles by division
    logic [QUO_W-1:0] lon_q;
    logic [QUO_W-1:0] lat_q;

    dnps_div u_div_lon
    (
        .clk     (clk),
        .num_in  ({pixel_x, {ANG_W{1'b0}}}),
        .den_in  (width_eff),
        .quo_out (lon_q)
    );

    dnps_div u_div_lat
    (
        .clk     (clk),
        .num_in  (NUM_W'({pixel_y, {ANG_W{1'b0}}})),
        .den_in  (lat_den),
        .quo_out (lat_q)
    );

    // Form the five sine arguments and fold them onto the table
    logic [ANG_W-1:0] dec_ang;
    sin_req_t req_sd, req_cd, req_sl, req_cl, req_ch;

    always_comb
    begin
        dec_ang = {{(ANG_W-14){sun_dec_reg[13]}}, sun_dec_reg};
        req_sd  = sin_req(dec_ang);
        req_cd  = sin_req(dec_ang + QUARTER_TURN);
        req_sl  = sin_req(lat_q - QUARTER_TURN);
        req_cl  = sin_req(lat_q);
        req_ch  = sin_req(sun_lon_reg - lon_q + QUARTER_TURN);
    end

    logic [TAB_DW-1:0] rd_sd, rd_cd, rd_sl, rd_cl, rd_ch;

    dnps_sin_rom u_rom_sd (.clk(clk), .addr(req_sd.addr), .data(rd_sd));
    dnps_sin_rom u_rom_cd (.clk(clk), .addr(req_cd.addr), .data(rd_cd));
    dnps_sin_rom u_rom_sl (.clk(clk), .addr(req_sl.addr), .data(rd_sl));
    dnps_sin_rom u_rom_cl (.clk(clk), .addr(req_cl.addr), .data(rd_cl));
    dnps_sin_rom u_rom_ch (.clk(clk), .addr(req_ch.addr), .data(rd_ch));

    // Hold the sign flags beside the ROM read
    logic [4:0] neg_reg;

    always_ff @(posedge clk)
    begin
        neg_reg <= {req_sd.neg, req_cd.neg, req_sl.neg, req_cl.neg, req_ch.neg};
    end

    function automatic logic signed [SV_W-1:0] apply_sign(logic neg,
                                                         logic [TAB_DW-1:0] v);
        logic signed [SV_W-1:0] s;
        s = signed'({1'b0, v});
        return neg ? -s : s;
    endfunction

    // Apply signs
    logic signed [SV_W-1:0] sd_reg, cd_reg, sl_reg, cl_reg, ch_reg;

    always_ff @(posedge clk)
    begin
        sd_reg <= apply_sign(neg_reg[4], rd_sd);
        cd_reg <= apply_sign(neg_reg[3], rd_cd);
        sl_reg <= apply_sign(neg_reg[2], rd_sl);
        cl_reg <= apply_sign(neg_reg[1], rd_cl);
        ch_reg <= apply_sign(neg_reg[0], rd_ch);
    end

    // First products
    logic signed [P1_W-1:0] p1_reg, p2_reg;
    logic signed [SV_W-1:0] ch_m_reg;

    always_ff @(posedge clk)
    begin
        p1_reg   <= sd_reg * sl_reg;
        p2_reg   <= cd_reg * cl_reg;
        ch_m_reg <= ch_reg;
    end

    // Second product
    logic signed [P1_W-1:0] p1_d_reg;
    logic signed [P3_W-1:0] p3_reg;

    always_ff @(posedge clk)
    begin
        p1_d_reg <= p1_reg;
        p3_reg   <= p2_reg * ch_m_reg;
    end

    // Sum, take the sign and pick the output pixel
    logic signed [SUM_W-1:0] sum_c;
    logic                    dark_c;
    logic [PIX_W-1:0]        pix_c;

    always_comb
    begin
        sum_c  = (SUM_W'(p1_d_reg) <<< TRIG_FRACTION_BITS) + SUM_W'(p3_reg);
        dark_c = sum_c[SUM_W-1];
        if (mono_reg)
            pix_c = {{(PIX_W-1){1'b0}}, day_reg[ST_M2][0] ^ dark_c};
        else
            pix_c = dark_c ? night_reg[ST_M2] : day_reg[ST_M2];
    end

    logic             done_reg;
    logic [PIX_W-1:0] pixel_out_reg;
    logic             is_dark_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= vld_reg[ST_M2];
    end

    always_ff @(posedge clk)
    begin
        pixel_out_reg <= pix_c;
        is_dark_reg   <= dark_c;
    end

    assign done      = done_reg;
    assign pixel_out = pixel_out_reg;
    assign is_dark   = is_dark_reg;

    // Checks on the pipeline timing and mono output
    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_LAT + 1))
        else $error("result without an item issued");

    a_start_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(PIPE_LAT + 1) done)
        else $error("item issued but no result delivered");

    a_mono_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(mono_reg)) |-> (pixel_out[PIX_W-1:1] == '0))
        else $error("mono result has upper bits set");

    a_stage_valid: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_T] |-> $past(vld_reg[ST_R]))
        else $error("valid bit skipped a stage");

endmodule

>>> dv/dnps_checker.sv
// Checker for the day/night pixel shader: tracks the APB registers, predicts
// the shaded pixel for each accepted item and compares results in order.
// Depends on dnps_pkg for widths and register indexes.
`timescale 1ns / 1ps

module dnps_checker import dnps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic              busy,
    input  logic [X_W-1:0]    pixel_x,
    input  logic [Y_W-1:0]    pixel_y,
    input  logic [PIX_W-1:0]  day_pixel,
    input  logic [PIX_W-1:0]  night_pixel,
    input  logic              done,
    input  logic [PIX_W-1:0]  pixel_out,
    input  logic              is_dark,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                fail_count,
    output int                pending
);

    typedef struct packed {
        logic [PIX_W-1:0] shade;
        logic             dark;
    } shade_t;

    // Shadow copy of the configuration
    logic [15:0]    sun_lon;
    logic [13:0]    sun_dec;
    logic [W_W-1:0] map_w;
    logic [H_W-1:0] map_h;
    logic           mono;

    shade_t    shade_q[$];
    longint    quarter_sine[0:1024];

    // Quarter-wave sine table, round(sin(i*pi/2048) * 2^16) by Taylor series
    initial
    begin
        longint unsigned t, term;
        longint acc;
        for (int i = 0; i <= 1024; i++)
        begin
            t    = (longint'(i) * 64'd3373259426) >> 11;
            term = t;
            acc  = longint'(t);
            for (int k = 1; k <= 6; k++)
            begin
                term = (((term * t) >> 30) * t) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                acc  = (k % 2) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0)
                acc = 0;
            quarter_sine[i] = (acc + (longint'(1) << (29 - TRIG_FRACTION_BITS)))
                              >>> (30 - TRIG_FRACTION_BITS);
        end
    end

    function automatic longint sine_of(logic [15:0] a);
        int unsigned j;
        longint v;
        j = a[13:4];
        v = a[14] ? quarter_sine[1024 - j] : quarter_sine[j];
        return a[15] ? -v : v;
    endfunction

    function automatic longint cosine_of(logic [15:0] a);
        return sine_of(a + 16'h4000);
    endfunction

    // Shade one pixel under the current register values
    function automatic shade_t shade_pixel(logic [X_W-1:0] x, logic [Y_W-1:0] y,
                                           logic [PIX_W-1:0] dp, logic [PIX_W-1:0] np);
        int unsigned w, h;
        logic [15:0] dec, lon, lat, hr;
        longint sum;
        shade_t r;
        w = (map_w == 0) ? 1 : map_w;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h   = (map_h == 0) ? 1 : map_h;
        dec = {{2{sun_dec[13]}}, sun_dec};
        lon = 16'((65536 * x) / w);
        lat = 16'((65536 * y) / (2 * h) - 16384);
        hr  = sun_lon - lon;
        sum = sine_of(dec) * sine_of(lat) * (longint'(1) << TRIG_FRACTION_BITS)
            + cosine_of(dec) * cosine_of(lat) * cosine_of(hr);
        r.dark  = (sum < 0);
        r.shade = mono ? PIX_W'(dp[0] ^ r.dark) : (r.dark ? np : dp);
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    // Track register writes, queue predictions and compare each result
    always @(posedge clk or negedge rst_n)
    begin
        shade_t want;
        if (!rst_n)
        begin
            sun_lon <= '0;
            sun_dec <= '0;
            map_w   <= 9'd256;
            map_h   <= 8'd128;
            mono    <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[4:2])
                    REG_SUN_LON: sun_lon <= pwdata[15:0];
                    REG_SUN_DEC: sun_dec <= pwdata[13:0];
                    REG_WIDTH:   map_w   <= pwdata[W_W-1:0];
                    REG_HEIGHT:  map_h   <= pwdata[H_W-1:0];
                    REG_MONO:    mono    <= pwdata[0];
                    default: ;
                endcase
            end
            if (done)
            begin
                if (shade_q.size() == 0)
                    report("result with no item outstanding", 1, 0);
                else
                begin
                    want = shade_q.pop_front();
                    if (pixel_out !== want.shade)
                        report("pixel_out", pixel_out, want.shade);
                    if (is_dark !== want.dark)
                        report("is_dark", is_dark, want.dark);
                end
            end
            if (start && !busy)
                shade_q.push_back(shade_pixel(pixel_x, pixel_y, day_pixel, night_pixel));
            pending = shade_q.size();
        end
    end

endmodule

>>> dv/tb_day_night_pixel_shader_top.sv
// Testbench top for the day/night pixel shader: drives pixel items and APB
// register writes; dnps_checker predicts and compares. Depends on dnps_pkg.
`timescale 1ns / 1ps

module tb_day_night_pixel_shader_top;
    import dnps_pkg::*;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic [X_W-1:0]    pixel_x;
    logic [Y_W-1:0]    pixel_y;
    logic [PIX_W-1:0]  day_pixel;
    logic [PIX_W-1:0]  night_pixel;
    logic              done;
    logic [PIX_W-1:0]  pixel_out;
    logic              is_dark;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count;
    int                pending;
    int                cycle_count;
    int unsigned       cur_w;

    day_night_pixel_shader_top dut (.*);

    dnps_checker u_checker (.*);

    // Clock, 10 ns period
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 400000)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Issue one item; start stays high on return, the caller drops it on a gap
    task automatic send_pixel(int unsigned x, int unsigned y, int unsigned dp, int unsigned np);
        start       <= 1'b1;
        pixel_x     <= X_W'(x);
        pixel_y     <= Y_W'(y);
        day_pixel   <= PIX_W'(dp);
        night_pixel <= PIX_W'(np);
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic hold_off(bit no_gaps);
        int unsigned r, n;
        r = $urandom_range(0, 19);
        n = 0;
        if (!no_gaps)
            n = (r < 11) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Drain: stop issuing, wait for every result, let the pipeline settle
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int unsigned x, y, sel;
        bit burst;
        cycle_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        pixel_x     = '0;
        pixel_y     = '0;
        day_pixel   = '0;
        night_pixel = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: corners of the map, colour at reset values, then mono
        send_pixel(0, 0, 8'hFF, 8'h00);
        send_pixel(255, 127, 8'h00, 8'hFF);
        send_pixel(128, 64, 8'hA5, 8'h5A);
        send_pixel(64, 32, 8'h5A, 8'hA5);
        send_pixel(192, 100, 8'h01, 8'hFE);
        drain();
        reg_write(REG_MONO, 1);
        reg_write(REG_SUN_DEC, 32'(-4260));
        reg_write(REG_SUN_LON, 16'hFFFF);
        send_pixel(0, 127, 8'h01, 8'hFF);
        send_pixel(255, 0, 8'hFE, 8'h00);
        send_pixel(32, 64, 8'hFF, 8'h00);
        send_pixel(160, 64, 8'h00, 8'hFF);
        drain();
        // Zero sizes count as one; oversize width clamps; pixels off the map wrap
        reg_write(REG_MONO, 0);
        reg_write(REG_SUN_DEC, 4260);
        reg_write(REG_WIDTH, 0);
        reg_write(REG_HEIGHT, 0);
        send_pixel(0, 0, 8'h11, 8'h22);
        send_pixel(255, 127, 8'h33, 8'h44);
        send_pixel(1, 1, 8'h55, 8'h66);
        drain();
        reg_write(REG_WIDTH, 511);
        reg_write(REG_HEIGHT, 255);
        reg_write(REG_SUN_DEC, 14'h1FFF);
        send_pixel(255, 127, 8'h77, 8'h88);
        send_pixel(100, 50, 8'h99, 8'hAA);
        drain();
        reg_write(REG_WIDTH, 1);
        reg_write(REG_HEIGHT, 1);
        reg_write(REG_SUN_DEC, 14'h2000);
        send_pixel(0, 0, 8'hBB, 8'hCC);
        send_pixel(7, 3, 8'hDD, 8'hEE);
        drain();

        // Random phases, each under a fresh register setting
        for (int phase = 0; phase < 10; phase++)
        begin
            sel = $urandom_range(0, 9);
            cur_w = (sel == 0) ? 1 : (sel == 1) ? 256 : (sel == 2) ? 0 :
                    (sel == 3) ? $urandom_range(257, 511) : $urandom_range(1, 256);
            reg_write(REG_WIDTH, cur_w);
            sel = $urandom_range(0, 9);
            reg_write(REG_HEIGHT, (sel == 0) ? 1 : (sel == 1) ? 128 : (sel == 2) ? 0 :
                      (sel == 3) ? $urandom_range(129, 255) : $urandom_range(1, 128));
            sel = $urandom_range(0, 9);
            reg_write(REG_SUN_DEC, (sel == 0) ? 32'(-4260) : (sel == 1) ? 32'd4260 :
                      (sel == 2) ? $urandom_range(0, 16383) :
                      32'($urandom_range(0, 8520)) - 32'd4260);
            reg_write(REG_SUN_LON, $urandom_range(0, 65535));
            reg_write(REG_MONO, phase % 2);
            if (cur_w == 0 || cur_w > 256)
                cur_w = (cur_w == 0) ? 1 : 256;
            burst = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++)
            begin
                // Mostly on-map pixels, some anywhere
                if ($urandom_range(0, 7) == 0)
                begin
                    x = $urandom_range(0, 255);
                    y = $urandom_range(0, 127);
                end
                else
                begin
                    x = $urandom_range(0, cur_w - 1);
                    y = $urandom_range(0, 127);
                end
                send_pixel(x, y, $urandom_range(0, 255), $urandom_range(0, 255));
                hold_off(burst);
            end
            drain();
        end

        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> day_night_pixel_shader_top.f
src/dnps_pkg.sv
src/dnps_sin_rom.sv
src/dnps_div.sv
src/day_night_pixel_shader_top.sv
dv/dnps_checker.sv
dv/tb_day_night_pixel_shader_top.sv
